// File: design/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and reset
`define TBEM_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset
`define TBEM_ASSERT(label, prop, msg) \
   `TBEM_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: design/tbem_pkg.sv
package tbem_pkg;

   // default sizing
   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_SAMPLE_BITS = 12;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int LIMIT_W     = 12;
   localparam int PCT_CFG_W   = 7;
   localparam int RUN_CFG_W   = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_LIMIT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CRITICAL_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PERCENT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RUN_LENGTH = 3'd4;

   localparam logic signed [LIMIT_W-1:0] RST_LOW_LIMIT      = 12'sd32;
   localparam logic signed [LIMIT_W-1:0] RST_HIGH_LIMIT     = 12'sd128;
   localparam logic signed [LIMIT_W-1:0] RST_CRITICAL_LIMIT = 12'sd192;
   localparam logic [PCT_CFG_W-1:0]      RST_MAX_PERCENT    = 7'd5;
   localparam logic [RUN_CFG_W-1:0]      RST_MAX_RUN_LENGTH = 13'd6;

   // summary field widths
   localparam int AVG_W       = 12;
   localparam int VAL_OUT_W   = 12;
   localparam int IDX_OUT_W   = 12;
   localparam int CNT_OUT_W   = 13;
   localparam int PCTX_W      = 11;
   localparam int VERDICT_W   = 2;
   localparam int RSP_TDATA_W = 112;

   // percent scaling
   localparam logic [10:0] PCT_X16_SCALE = 11'd1600;
   localparam logic [6:0]  PCT_FULL      = 7'd100;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_OBSERVED = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECTED = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic start_avg;
      logic cap_avg;
      logic start_pct;
      logic cap_pct;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: design/tbem_div.sv
module tbem_div #(
   parameter int DIV_W = 25,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int ITER_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: design/tbem_dp.sv
module tbem_dp #(
   parameter int MAX_SAMPLES = tbem_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = tbem_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tbem_pkg::cmd_type                   cmd,
   output tbem_pkg::status_type                status,
   input  logic signed [SAMPLE_BITS-1:0]       sample,
   input  logic                                csr_we,
   input  logic [tbem_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbem_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbem_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W     = $clog2(MAX_SAMPLES);
   localparam int SUM_W     = SAMPLE_BITS + CNT_W;
   localparam int PCT_NUM_W = CNT_W + $bits(tbem_pkg::PCT_X16_SCALE);
   localparam int CMP_W     = CNT_W + $bits(tbem_pkg::PCT_FULL);
   localparam int DIV_W     = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;

   // configuration registers
   logic signed [tbem_pkg::LIMIT_W-1:0] low_ff, high_ff, crit_ff;
   logic [tbem_pkg::PCT_CFG_W-1:0]      max_pct_ff;
   logic [tbem_pkg::RUN_CFG_W-1:0]      max_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= tbem_pkg::RST_LOW_LIMIT;
         high_ff    <= tbem_pkg::RST_HIGH_LIMIT;
         crit_ff    <= tbem_pkg::RST_CRITICAL_LIMIT;
         max_pct_ff <= tbem_pkg::RST_MAX_PERCENT;
         max_run_ff <= tbem_pkg::RST_MAX_RUN_LENGTH;
      end else if (csr_we) begin
         unique case (csr_index)
            tbem_pkg::REG_LOW_LIMIT:      low_ff     <= csr_wdata[tbem_pkg::LIMIT_W-1:0];
            tbem_pkg::REG_HIGH_LIMIT:     high_ff    <= csr_wdata[tbem_pkg::LIMIT_W-1:0];
            tbem_pkg::REG_CRITICAL_LIMIT: crit_ff    <= csr_wdata[tbem_pkg::LIMIT_W-1:0];
            tbem_pkg::REG_MAX_PERCENT:    max_pct_ff <= csr_wdata[tbem_pkg::PCT_CFG_W-1:0];
            tbem_pkg::REG_MAX_RUN_LENGTH: max_run_ff <= csr_wdata[tbem_pkg::RUN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // batch statistics
   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in, min_ff, min_in;
   logic [IDX_W-1:0]              max_idx_ff, max_idx_in, min_idx_ff, min_idx_in;
   logic [CNT_W-1:0]              outside_ff, outside_in;
   logic [CNT_W-1:0]              cur_run_ff, cur_run_in;
   logic [IDX_W-1:0]              cur_start_ff, cur_start_in;
   logic [CNT_W-1:0]              long_run_ff, long_run_in;
   logic signed [IDX_W:0]         long_start_ff, long_start_in;
   logic                          ovf_ff, ovf_in;

   logic             room;
   logic             first;
   logic             outside;
   logic [IDX_W-1:0] idx;

   assign room    = count_ff < CNT_W'(MAX_SAMPLES);
   assign first   = count_ff == '0;
   assign idx     = count_ff[IDX_W-1:0];
   assign outside = (sample < low_ff) || (sample > high_ff);

   // per-request update
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      max_in        = max_ff;
      max_idx_in    = max_idx_ff;
      min_in        = min_ff;
      min_idx_in    = min_idx_ff;
      outside_in    = outside_ff;
      cur_run_in    = cur_run_ff;
      cur_start_in  = cur_start_ff;
      long_run_in   = long_run_ff;
      long_start_in = long_start_ff;
      ovf_in        = ovf_ff;
      if (cmd.load_out) begin
         count_in      = '0;
         sum_in        = '0;
         max_in        = '0;
         max_idx_in    = '0;
         min_in        = '0;
         min_idx_in    = '0;
         outside_in    = '0;
         cur_run_in    = '0;
         cur_start_in  = '0;
         long_run_in   = '0;
         long_start_in = '1;
         ovf_in        = 1'b0;
      end else if (cmd.accept) begin
         if (room) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(sample);
            if (first || sample > max_ff) begin
               max_in     = sample;
               max_idx_in = idx;
            end
            if (first || sample < min_ff) begin
               min_in     = sample;
               min_idx_in = idx;
            end
            if (outside) begin
               outside_in = outside_ff + 1'b1;
               if (cur_run_ff == '0) begin
                  cur_start_in = idx;
               end
               cur_run_in = cur_run_ff + 1'b1;
               // strictly longer run replaces the best
               if (cur_run_in > long_run_ff) begin
                  long_run_in   = cur_run_in;
                  long_start_in = {1'b0, cur_start_in};
               end
            end else begin
               cur_run_in = '0;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         max_ff        <= '0;
         max_idx_ff    <= '0;
         min_ff        <= '0;
         min_idx_ff    <= '0;
         outside_ff    <= '0;
         cur_run_ff    <= '0;
         cur_start_ff  <= '0;
         long_run_ff   <= '0;
         long_start_ff <= '1;
         ovf_ff        <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         max_ff        <= max_in;
         max_idx_ff    <= max_idx_in;
         min_ff        <= min_in;
         min_idx_ff    <= min_idx_in;
         outside_ff    <= outside_in;
         cur_run_ff    <= cur_run_in;
         cur_start_ff  <= cur_start_in;
         long_run_ff   <= long_run_in;
         long_start_ff <= long_start_in;
         ovf_ff        <= ovf_in;
      end
   end

   // end-of-batch products, registered before use
   logic [PCT_NUM_W-1:0] pct_num_ff;
   logic [CMP_W-1:0]     out100_ff, limit_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_avg) begin
         pct_num_ff   <= PCT_NUM_W'(outside_ff) * PCT_NUM_W'(tbem_pkg::PCT_X16_SCALE);
         out100_ff    <= CMP_W'(outside_ff) * CMP_W'(tbem_pkg::PCT_FULL);
         limit_cnt_ff <= CMP_W'(max_pct_ff) * CMP_W'(count_ff);
      end
   end

   // shared divider: |sum| / count, then out_count * 1600 / count
   logic             sum_neg;
   logic [SUM_W-1:0] sum_abs;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_quot;
   logic             div_done;

   assign sum_neg      = sum_ff[SUM_W-1];
   assign sum_abs      = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_dividend = cmd.start_avg ? DIV_W'(sum_abs) : DIV_W'(pct_num_ff);

   tbem_div #(
      .DIV_W (DIV_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_avg | cmd.start_pct),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .quotient (div_quot),
      .done     (div_done)
   );

   // quotient capture, mean truncated toward zero
   logic signed [DIV_W:0]              quot_s;
   logic signed [DIV_W:0]              avg_full;
   logic signed [tbem_pkg::AVG_W-1:0]  avg_ff;
   logic [tbem_pkg::PCTX_W-1:0]        pct_ff;

   assign quot_s   = {1'b0, div_quot};
   assign avg_full = sum_neg ? -quot_s : quot_s;

   always_ff @(posedge clock) begin
      if (cmd.cap_avg) begin
         avg_ff <= avg_full[tbem_pkg::AVG_W-1:0];
      end
      if (cmd.cap_pct) begin
         pct_ff <= div_quot[tbem_pkg::PCTX_W-1:0];
      end
   end

   // verdict
   logic [tbem_pkg::VERDICT_W-1:0] verdict;

   always_comb begin
      priority if ((max_ff > crit_ff) || (long_run_ff > max_run_ff)) begin
         verdict = tbem_pkg::VERDICT_REJECTED;
      end else if (out100_ff > limit_cnt_ff) begin
         verdict = tbem_pkg::VERDICT_OBSERVED;
      end else begin
         verdict = tbem_pkg::VERDICT_ACCEPTED;
      end
   end

   // summary output register
   logic                             rsp_valid_ff;
   logic [tbem_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                             rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {verdict,
                         tbem_pkg::CNT_OUT_W'(long_start_ff),
                         tbem_pkg::CNT_OUT_W'(long_run_ff),
                         pct_ff,
                         tbem_pkg::CNT_OUT_W'(outside_ff),
                         tbem_pkg::IDX_OUT_W'(min_idx_ff),
                         tbem_pkg::VAL_OUT_W'(min_ff),
                         tbem_pkg::IDX_OUT_W'(max_idx_ff),
                         tbem_pkg::VAL_OUT_W'(max_ff),
                         avg_ff};
         rsp_user_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// File: design/tbem_ctrl.sv
module tbem_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   input  tbem_pkg::status_type status,
   output logic                 req_tready,
   output tbem_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_RUN  = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIVA = 3'd2;
   localparam logic [2:0] ST_DIVP = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   // batch sequencing: collect, scale, two divides, hand over
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.start_avg = 1'b1;
            state_in      = ST_DIVA;
         end
         ST_DIVA: begin
            if (status.div_done) begin
               cmd.cap_avg   = 1'b1;
               cmd.start_pct = 1'b1;
               state_in      = ST_DIVP;
            end
         end
         ST_DIVP: begin
            if (status.div_done) begin
               cmd.cap_pct = 1'b1;
               state_in    = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/temperature_batch_excursion_monitor.sv
// Samples: one request a cycle while a batch is being collected.
// Last sample: the summary is worked out by one shared shift-subtract divider doing mean and
// percentage in turn, a bit a cycle, before it is loaded into the output register.
// No request is taken from the last sample until the summary is loaded into the output
// register, and that load waits while an earlier summary is still held there.
// Synchronous active-high reset: statistics cleared, limits at defaults, no summary pending.
module temperature_batch_excursion_monitor #(
   parameter int MAX_SAMPLES = tbem_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = tbem_pkg::DEF_SAMPLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,   // sample
   input  logic                             req_tlast,
   // summary stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // average, max_value, max_index, min_value, min_index, out_count,
   // out_percent_x16, run_length, run_start, verdict
   output logic [tbem_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,   // overflow
   // configuration
   input  logic                             csr_we,
   input  logic [tbem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbem_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tbem_pkg::cmd_type    cmd;
   tbem_pkg::status_type status;

   tbem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   tbem_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/tbem_chk.sv
`include "assert_macros.svh"

module tbem_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tbem_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a held summary keeps its contents
   `TBEM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "summary changed while stalled")

   // batch end stops intake while the summary is worked out
   `TBEM_ASSERT(a_last_stalls, req_tvalid && req_tready && req_tlast |=> !req_tready, "request taken right after batch end")

   // verdict is one of the three codes
   `TBEM_ASSERT(a_verdict_code, rsp_tvalid |-> rsp_tdata[111:110] != 2'd3, "bad verdict code")

   // no run means start of -1, and a run means a real start
   `TBEM_ASSERT(a_run_start, rsp_tvalid |-> ((rsp_tdata[96:84] == 13'd0) == (rsp_tdata[109:97] == 13'h1fff)), "run start and length disagree")

   // the longest run is among the counted excursions, and min never above max
   `TBEM_ASSERT(a_stats_order, rsp_tvalid |-> (rsp_tdata[72:60] >= rsp_tdata[96:84]) && ($signed(rsp_tdata[23:12]) >= $signed(rsp_tdata[47:36])), "summary statistics inconsistent")

endmodule

bind temperature_batch_excursion_monitor tbem_chk u_tbem_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int HELD_MAX      = tbem_pkg::DEF_MAX_SAMPLES;
   localparam int SAMPLE_W      = tbem_pkg::DEF_SAMPLE_BITS;
   localparam int REQ_W         = ((SAMPLE_W + 7) / 8) * 8;

   // one batch summary as the block should report it
   typedef struct {
      logic signed [tbem_pkg::AVG_W-1:0]     average;
      logic signed [tbem_pkg::VAL_OUT_W-1:0] max_value;
      logic [tbem_pkg::IDX_OUT_W-1:0]        max_index;
      logic signed [tbem_pkg::VAL_OUT_W-1:0] min_value;
      logic [tbem_pkg::IDX_OUT_W-1:0]        min_index;
      logic [tbem_pkg::CNT_OUT_W-1:0]        out_count;
      logic [tbem_pkg::PCTX_W-1:0]           out_pct_x16;
      logic [tbem_pkg::CNT_OUT_W-1:0]        run_length;
      logic signed [tbem_pkg::CNT_OUT_W-1:0] run_start;
      logic [tbem_pkg::VERDICT_W-1:0]        verdict;
      logic                                  overflow;
   } batch_summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [REQ_W-1:0]                 req_tdata  = '0;   // sample
   logic                             req_tlast  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // average, max_value, max_index, min_value, min_index, out_count,
   // out_percent_x16, run_length, run_start, verdict
   logic [tbem_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;        // overflow
   logic                             csr_we     = 1'b0;
   logic [tbem_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [tbem_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   temperature_batch_excursion_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // limits as the block should hold them
   int cfg_low, cfg_high, cfg_critical, cfg_pct_limit, cfg_run_limit;

   // running tally of the open batch
   int     held;
   longint batch_sum;
   int     peak_hi, peak_hi_at, peak_lo, peak_lo_at;
   int     excursion_total;
   int     streak_len, streak_from, longest_streak, longest_streak_from;
   bit     batch_overflowed;

   batch_summary_type summaries_due[$];
   batch_summary_type want;
   int mismatches     = 0;
   int summaries_seen = 0;
   int items_sent     = 0;
   int cycles         = 0;
   int burst_left     = 0;
   bit sender_steady  = 1'b0;
   bit rx_full_speed  = 1'b0;
   int rx_left        = 0;
   bit rx_open        = 1'b0;

   function automatic void clear_tally();
      held                = 0;
      batch_sum           = 0;
      peak_hi             = 0;
      peak_hi_at          = 0;
      peak_lo             = 0;
      peak_lo_at          = 0;
      excursion_total     = 0;
      streak_len          = 0;
      streak_from         = 0;
      longest_streak      = 0;
      longest_streak_from = -1;
      batch_overflowed    = 1'b0;
   endfunction

   // fold one accepted sample into the tally; close the batch on last
   function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] s, bit is_last);
      batch_summary_type sm;
      int                v;
      longint            avg;
      longint            pct;
      v = s;
      if (held < HELD_MAX) begin
         batch_sum += v;
         if (held == 0) begin
            peak_hi = v; peak_hi_at = 0;
            peak_lo = v; peak_lo_at = 0;
         end else begin
            if (v > peak_hi) begin peak_hi = v; peak_hi_at = held; end
            if (v < peak_lo) begin peak_lo = v; peak_lo_at = held; end
         end
         if (v < cfg_low || v > cfg_high) begin
            excursion_total++;
            if (streak_len == 0) streak_from = held;
            streak_len++;
            // a later run only wins when strictly longer
            if (streak_len > longest_streak) begin
               longest_streak      = streak_len;
               longest_streak_from = streak_from;
            end
         end else begin
            streak_len = 0;
         end
         held++;
      end else begin
         batch_overflowed = 1'b1;
      end
      if (!is_last) return;

      avg = 0;
      pct = 0;
      if (held != 0) begin
         avg = batch_sum / longint'(held);
         pct = (longint'(excursion_total) * 1600) / longint'(held);
      end
      sm.average     = avg[tbem_pkg::AVG_W-1:0];
      sm.max_value   = peak_hi[tbem_pkg::VAL_OUT_W-1:0];
      sm.max_index   = peak_hi_at[tbem_pkg::IDX_OUT_W-1:0];
      sm.min_value   = peak_lo[tbem_pkg::VAL_OUT_W-1:0];
      sm.min_index   = peak_lo_at[tbem_pkg::IDX_OUT_W-1:0];
      sm.out_count   = excursion_total[tbem_pkg::CNT_OUT_W-1:0];
      sm.out_pct_x16 = pct[tbem_pkg::PCTX_W-1:0];
      sm.run_length  = longest_streak[tbem_pkg::CNT_OUT_W-1:0];
      sm.run_start   = longest_streak_from[tbem_pkg::CNT_OUT_W-1:0];
      sm.overflow    = batch_overflowed;
      if (peak_hi > cfg_critical || longest_streak > cfg_run_limit)
         sm.verdict = tbem_pkg::VERDICT_REJECTED;
      else if (longint'(excursion_total) * 100 > longint'(cfg_pct_limit) * longint'(held))
         sm.verdict = tbem_pkg::VERDICT_OBSERVED;
      else
         sm.verdict = tbem_pkg::VERDICT_ACCEPTED;
      summaries_due.push_back(sm);
      clear_tally();
   endfunction

   function automatic int clamp_sample(int v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return v;
   endfunction

   function automatic int any_sample();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // sample inside or outside the current limits, biased to the edges
   function automatic int pick_sample(bit excursion);
      int  r;
      int  v;
      bit  below_ok;
      bit  above_ok;
      r        = $urandom_range(0, 99);
      below_ok = cfg_low > -2048;
      above_ok = cfg_high < 2047;
      if (r < 8)
         v = (r < 4) ? -2048 : 2047;
      else if (r < 20 && !excursion)
         v = any_sample();
      else if (excursion) begin
         if (below_ok && (!above_ok || $urandom_range(0, 1) == 0))
            v = cfg_low - 1 - int'($urandom_range(0, 30));
         else if (above_ok)
            v = cfg_high + 1 + int'($urandom_range(0, 30));
         else
            v = any_sample();
      end else if (cfg_low <= cfg_high)
         v = cfg_low + int'($urandom_range(0, cfg_high - cfg_low));
      else
         v = any_sample();
      return clamp_sample(v);
   endfunction

   // request driver: holds valid until the handshake
   task automatic send_sample(int s, bit is_last);
      logic signed [SAMPLE_W-1:0] smp;
      smp = SAMPLE_W'(s);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = '0;
      req_tdata[SAMPLE_W-1:0] = smp;
      req_tlast  = is_last;
      do @(posedge clock); while (!req_tready);
      absorb_sample(smp, is_last);
      items_sent++;
   endtask

   task automatic send_batch(input int vals[$]);
      foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
   endtask

   // sender bursts with random gaps
   task automatic sender_breather();
      int gap;
      if (burst_left == 0) begin
         if (!sender_steady) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
               @(negedge clock);
               req_tvalid = 1'b0;
            end
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // hold off until every summary is back and the divider has settled
   task automatic drain_summaries();
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (summaries_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [tbem_pkg::CSR_INDEX_W-1:0] idx, int value);
      logic [tbem_pkg::CSR_DATA_W-1:0] wd;
      wd = tbem_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = wd;
      case (idx)
         tbem_pkg::REG_LOW_LIMIT:      cfg_low       = $signed(wd[tbem_pkg::LIMIT_W-1:0]);
         tbem_pkg::REG_HIGH_LIMIT:     cfg_high      = $signed(wd[tbem_pkg::LIMIT_W-1:0]);
         tbem_pkg::REG_CRITICAL_LIMIT: cfg_critical  = $signed(wd[tbem_pkg::LIMIT_W-1:0]);
         tbem_pkg::REG_MAX_PERCENT:    cfg_pct_limit = wd[tbem_pkg::PCT_CFG_W-1:0];
         tbem_pkg::REG_MAX_RUN_LENGTH: cfg_run_limit = wd[tbem_pkg::RUN_CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_limits(int lo, int hi, int crit, int pct, int run);
      write_register(tbem_pkg::REG_LOW_LIMIT, lo);
      write_register(tbem_pkg::REG_HIGH_LIMIT, hi);
      write_register(tbem_pkg::REG_CRITICAL_LIMIT, crit);
      write_register(tbem_pkg::REG_MAX_PERCENT, pct);
      write_register(tbem_pkg::REG_MAX_RUN_LENGTH, run);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic randomise_limits();
      int lo, hi, crit, pct, run, r;
      if ($urandom_range(0, 4) == 0) begin
         lo   = any_sample();
         hi   = any_sample();
         crit = any_sample();
      end else begin
         lo   = int'($urandom_range(0, 500)) - 250;
         hi   = clamp_sample(lo + int'($urandom_range(0, 300)));
         crit = clamp_sample(hi + int'($urandom_range(0, 200)) - 50);
      end
      r   = $urandom_range(0, 99);
      pct = (r < 10) ? 127 : $urandom_range(0, 100);
      r   = $urandom_range(0, 99);
      run = (r < 10) ? 8191 : (r < 15) ? 4096 : $urandom_range(0, 10);
      apply_limits(lo, hi, crit, pct, run);
   endtask

   task automatic run_random_batch(int len);
      bit excursion;
      excursion = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         sender_breather();
         if ($urandom_range(0, 99) < 25) excursion = !excursion;
         send_sample(pick_sample(excursion), i == len - 1);
      end
   endtask

   // reset limits: single samples at the rails, first-occurrence ties,
   // equal-length runs, negative mean truncation, rejected and observed verdicts
   task automatic test_directed_batches();
      int plan[$];
      plan = {2047};                               send_batch(plan);
      plan = {-2048};                              send_batch(plan);
      plan = {50, 100, 2047, -2048, 2047, -2048, 60}; send_batch(plan);
      plan = {0, 0, 50, 300, 300, 50};             send_batch(plan);
      plan = {-3, -2};                             send_batch(plan);
      plan = {0, 40, 40, 40};                      send_batch(plan);
      drain_summaries();
   endtask

   // extreme and ordinary register settings, a few batches each
   task automatic test_register_settings();
      apply_limits(-2048, 2047, 2047, 0, 0);
      repeat (3) run_random_batch($urandom_range(1, 12));
      drain_summaries();
      apply_limits(2047, -2048, -2048, 100, 4096);
      repeat (3) run_random_batch($urandom_range(1, 12));
      drain_summaries();
      apply_limits(0, 0, 0, 127, 8191);
      repeat (3) run_random_batch($urandom_range(1, 12));
      drain_summaries();
      apply_limits(-50, 50, 100, 50, 3);
      repeat (3) run_random_batch($urandom_range(1, 12));
      drain_summaries();
   endtask

   // a full store with one unbroken excursion, then a batch past the store
   task automatic test_overflow();
      int len;
      apply_limits(-100, 100, 2047, 100, 4096);
      len = HELD_MAX;
      for (int i = 0; i < len; i++) send_sample(pick_sample(1'b1), i == len - 1);
      len = HELD_MAX + 7;
      for (int i = 0; i < len; i++) send_sample(pick_sample(1'b1), i == len - 1);
      drain_summaries();
   endtask

   task automatic test_random_batches();
      int batches;
      int len;
      batches    = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (batches % 12 == 0) begin
            drain_summaries();
            randomise_limits();
         end else if ($urandom_range(0, 19) == 0) begin
            drain_summaries();
         end
         // every so often a stretch with no idling on either side
         sender_steady = (batches % 25) >= 20;
         rx_full_speed = sender_steady;
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 80);
         run_random_batch(len);
         batches++;
      end
      sender_steady = 1'b0;
      rx_full_speed = 1'b0;
      drain_summaries();
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_left = $urandom_range(1, 12);
         rx_open = ($urandom_range(0, 99) < 60);
      end
      rx_left--;
      rsp_tready = rx_full_speed || rx_open;
   end

   function automatic void check_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("summary %0d %s: expected %0d, got %0d",
                     summaries_seen, name, exp_v, got_v);
      end
   endfunction

   // summary checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (summaries_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("summary %0d not expected: tdata %h", summaries_seen, rsp_tdata);
         end else begin
            want = summaries_due.pop_front();
            check_field("average", want.average, $signed(rsp_tdata[11:0]));
            check_field("max_value", want.max_value, $signed(rsp_tdata[23:12]));
            check_field("max_index", want.max_index, rsp_tdata[35:24]);
            check_field("min_value", want.min_value, $signed(rsp_tdata[47:36]));
            check_field("min_index", want.min_index, rsp_tdata[59:48]);
            check_field("out_count", want.out_count, rsp_tdata[72:60]);
            check_field("out_percent_x16", want.out_pct_x16, rsp_tdata[83:73]);
            check_field("run_length", want.run_length, rsp_tdata[96:84]);
            check_field("run_start", want.run_start, $signed(rsp_tdata[109:97]));
            check_field("verdict", want.verdict, rsp_tdata[111:110]);
            check_field("overflow", want.overflow, rsp_tuser);
         end
         summaries_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      cfg_low       = tbem_pkg::RST_LOW_LIMIT;
      cfg_high      = tbem_pkg::RST_HIGH_LIMIT;
      cfg_critical  = tbem_pkg::RST_CRITICAL_LIMIT;
      cfg_pct_limit = tbem_pkg::RST_MAX_PERCENT;
      cfg_run_limit = tbem_pkg::RST_MAX_RUN_LENGTH;
      clear_tally();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_batches();
      test_register_settings();
      test_overflow();
      test_random_batches();

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
